[src/vtba_pkg.sv]
// Shared types, constants and format geometry tables for the VRAM bump allocator.
`timescale 1ns / 1ps
`default_nettype none

package vtba_pkg;

   localparam int ADDR_W = 21;
   localparam int SIZE_W = 23;
   localparam int DIM_W  = 12;
   localparam int FMT_W  = 4;
   localparam int ACT_W  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd2;

   localparam logic [FMT_W-1:0] FMT_LAST = 4'd12;

   localparam logic [SIZE_W-1:0] SIZE_SAT    = 23'h7F_FFFF;
   localparam logic [ADDR_W-1:0] LIMIT_RESET = 21'h10_0000;

   // register index taken from paddr[2]
   localparam logic REG_LIMIT = 1'b0;

   // 2x2 block section search: bounds on major and minor axis, offsets per set
   localparam logic [4:0] CASE_A [8] = '{5'd2, 5'd2, 5'd4, 5'd4, 5'd2, 5'd2, 5'd4, 5'd4};
   localparam logic [4:0] CASE_B [8] = '{5'd2, 5'd4, 5'd2, 5'd4, 5'd6, 5'd8, 5'd6, 5'd8};
   localparam logic [4:0] SECT_ADD [4][8] = '{
      '{5'd0,  5'd4,  5'd8,  5'd12, 5'd16, 5'd20, 5'd24, 5'd28},
      '{5'd24, 5'd28, 5'd16, 5'd20, 5'd8,  5'd12, 5'd0,  5'd4},
      '{5'd0,  5'd8,  5'd16, 5'd24, 5'd4,  5'd12, 5'd4,  5'd28},
      '{5'd24, 5'd16, 5'd8,  5'd0,  5'd28, 5'd20, 5'd12, 5'd4}};

   // Per-format geometry, dimensions as log2
   typedef struct packed {
      logic [2:0] page_w_log2;
      logic [2:0] page_h_log2;
      logic [2:0] blk_w_log2;
      logic [2:0] blk_h_log2;
      logic       tall;
      logic [1:0] sect_set;
   } fmt_geom_type;

   function automatic fmt_geom_type fmt_geom(input logic [FMT_W-1:0] fmt);
      fmt_geom_type g;
      unique case (fmt)
         4'd0, 4'd1, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10:
            g = '{3'd6, 3'd5, 3'd3, 3'd3, 1'b0, 2'd0};
         4'd2:  g = '{3'd6, 3'd6, 3'd4, 3'd3, 1'b1, 2'd0};
         4'd3:  g = '{3'd6, 3'd6, 3'd4, 3'd3, 1'b1, 2'd2};
         4'd4:  g = '{3'd7, 3'd6, 3'd4, 3'd4, 1'b0, 2'd0};
         4'd5:  g = '{3'd7, 3'd7, 3'd5, 3'd4, 1'b1, 2'd0};
         4'd11: g = '{3'd6, 3'd6, 3'd4, 3'd3, 1'b1, 2'd1};
         4'd12: g = '{3'd6, 3'd6, 3'd4, 3'd3, 1'b1, 2'd3};
         default: g = '{3'd6, 3'd5, 3'd3, 3'd3, 1'b0, 2'd0};
      endcase
      return g;
   endfunction

   // Item between the size stage and the allocate stage
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic              fmt_ok;
      logic [SIZE_W-1:0] size_words;
      logic [ADDR_W-1:0] free_address;
   } stage_item_type;

endpackage

`default_nettype wire

[src/vtba_size.sv]
// Surface size calculation: page count, section offset, partial block count, alignment.
`timescale 1ns / 1ps
`default_nettype none

module vtba_size (
   input  wire logic [vtba_pkg::DIM_W-1:0]  surface_width,
   input  wire logic [vtba_pkg::DIM_W-1:0]  surface_height,
   input  wire logic [vtba_pkg::FMT_W-1:0]  pixel_format,
   input  wire logic                        align_to_page,
   output logic      [vtba_pkg::SIZE_W-1:0] size_words
);
   import vtba_pkg::*;

   fmt_geom_type geom;
   logic [6:0]  w_mask;
   logic [6:0]  h_mask;
   logic [12:0] w_sum;
   logic [12:0] h_sum;
   logic [6:0]  w_pages;
   logic [7:0]  h_pages;
   logic [6:0]  w_low;
   logic [6:0]  h_low;
   logic [7:0]  w_rem;
   logic [7:0]  h_rem;
   logic [14:0] pages;
   logic [14:0] pages_m1;
   logic [4:0]  major;
   logic [4:0]  minor;
   logic [4:0]  sect;
   logic        found;
   logic        major_odd;
   logic        minor_odd;
   logic [2:0]  quad;
   logic [18:0] blocks;
   logic [24:0] words;
   logic [24:0] aligned;

   assign geom = fmt_geom(pixel_format);

   assign w_mask = 7'((8'd1 << geom.page_w_log2) - 8'd1);
   assign h_mask = 7'((8'd1 << geom.page_h_log2) - 8'd1);

   // whole pages along each axis, rounded up
   assign w_sum   = {1'b0, surface_width} + {6'd0, w_mask};
   assign h_sum   = {1'b0, surface_height} + {6'd0, h_mask};
   assign w_pages = 7'(w_sum >> geom.page_w_log2);
   assign h_pages = 8'(h_sum >> geom.page_h_log2);

   // remainder in the last page, a full page when it divides evenly
   assign w_low = surface_width[6:0] & w_mask;
   assign h_low = surface_height[6:0] & h_mask;
   assign w_rem = (w_low == 7'd0) ? (8'd1 << geom.page_w_log2) : {1'b0, w_low};
   assign h_rem = (h_low == 7'd0) ? (8'd1 << geom.page_h_log2) : {1'b0, h_low};

   assign pages    = {8'd0, w_pages} * {7'd0, h_pages};
   assign pages_m1 = pages - 15'd1;

   always_comb begin
      if (geom.tall) begin
         major = 5'(w_rem >> geom.blk_w_log2);
         minor = 5'(h_rem >> geom.blk_h_log2);
      end else begin
         major = 5'(h_rem >> geom.blk_h_log2);
         minor = 5'(w_rem >> geom.blk_w_log2);
      end
   end

   // first section case whose bounds hold
   always_comb begin
      sect  = 5'd0;
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && major <= CASE_A[i] && minor <= CASE_B[i]) begin
            sect  = SECT_ADD[geom.sect_set][i];
            found = 1'b1;
         end
      end
   end

   // a zero count counts as one block, which is odd
   assign major_odd = major[0] | (major == 5'd0);
   assign minor_odd = minor[0] | (minor == 5'd0);
   assign quad      = {1'b0, ({major_odd, minor_odd} ^ 2'b11)} + 3'd1;

   assign blocks  = 19'({pages_m1, 5'd0}) + 19'(sect) + 19'(quad);
   assign words   = {blocks, 6'd0};
   assign aligned = align_to_page ? ((words + 25'd2047) & ~25'd2047) : words;

   always_comb begin
      if (surface_width == '0 || surface_height == '0) begin
         size_words = '0;
      end else if (aligned > 25'(SIZE_SAT)) begin
         size_words = SIZE_SAT;
      end else begin
         size_words = aligned[SIZE_W-1:0];
      end
   end

endmodule

`default_nettype wire

[src/vtba_alloc.sv]
// Free pointer register, allocate/free decision and result payload register.
`timescale 1ns / 1ps
`default_nettype none

module vtba_alloc (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               load,
   input  wire vtba_pkg::stage_item_type           item,
   input  wire logic [vtba_pkg::ADDR_W-1:0]        vram_limit,
   output logic      [vtba_pkg::ADDR_W-1:0]        result_address,
   output logic      [vtba_pkg::SIZE_W-1:0]        size_words,
   output logic                                    success,
   output logic      [vtba_pkg::ADDR_W-1:0]        free_words
);
   import vtba_pkg::*;

   logic [ADDR_W-1:0] free_ptr_ff;
   logic [ADDR_W-1:0] free_ptr_in;
   logic [ADDR_W-1:0] address_ff;
   logic [ADDR_W-1:0] address_in;
   logic [SIZE_W-1:0] size_ff;
   logic              success_ff;
   logic              success_in;
   logic [ADDR_W-1:0] free_words_ff;
   logic [ADDR_W-1:0] free_words_in;
   logic [23:0]       next_sum;
   logic              fits;

   assign next_sum = {3'd0, free_ptr_ff} + {1'b0, item.size_words};
   assign fits     = next_sum <= {3'd0, vram_limit};

   always_comb begin
      free_ptr_in = free_ptr_ff;
      address_in  = '0;
      success_in  = 1'b0;
      priority if (item.action == ACT_FREE) begin
         free_ptr_in = item.free_address;
         success_in  = 1'b1;
      end else if (item.fmt_ok) begin
         if (item.action == ACT_QUERY) begin
            success_in = 1'b1;
         end else if (item.action == ACT_ALLOC && fits) begin
            address_in  = free_ptr_ff;
            free_ptr_in = next_sum[ADDR_W-1:0];
            success_in  = 1'b1;
         end
      end else begin
         // unknown format: report failure and hold the pointer
         success_in = 1'b0;
      end
      free_words_in = (vram_limit > free_ptr_in) ? (vram_limit - free_ptr_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ptr_ff <= '0;
      end else if (load) begin
         free_ptr_ff <= free_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         address_ff    <= address_in;
         size_ff       <= item.size_words;
         success_ff    <= success_in;
         free_words_ff <= free_words_in;
      end
   end

   assign result_address = address_ff;
   assign size_words     = size_ff;
   assign success        = success_ff;
   assign free_words     = free_words_ff;

   a_ptr_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !load |=> $stable(free_ptr_ff))
      else $error("free pointer moved without a committed item");

   a_alloc_advances_ptr: assert property (@(posedge clock) disable iff (reset)
      (load && item.action == ACT_ALLOC && success_in) |=>
         ({3'd0, free_ptr_ff} == 24'(result_address) + 24'(size_words)))
      else $error("allocate did not advance pointer by its size");

   a_free_sets_ptr: assert property (@(posedge clock) disable iff (reset)
      (load && item.action == ACT_FREE) |=> (free_ptr_ff == $past(item.free_address)))
      else $error("free did not move the pointer to its address");

endmodule

`default_nettype wire

[src/vram_texture_bump_allocator_core.sv]
// Top level: input register, size stage, allocate stage and configuration port.
`timescale 1ns / 1ps
`default_nettype none

// VRAM bump allocator. Each request transfer is a size query, an allocate or a
// free. The block is a three-register pipeline (request register, size
// register, result register) and takes one request every cycle while
// req_stall is low; a request passes through those registers in order. The free pointer is
// updated in the last stage, so back-to-back allocates see each other's
// pointer without a bubble. rsp_stall holds every stage that has no room, and
// req_stall rises only when all three stages hold an item. The VRAM limit is
// written over the APB-style port at byte address 0 and reads back there.
module vram_texture_bump_allocator_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [vtba_pkg::ACT_W-1:0]         req_action,
   input  wire logic [vtba_pkg::DIM_W-1:0]         req_surface_width,
   input  wire logic [vtba_pkg::DIM_W-1:0]         req_surface_height,
   input  wire logic [vtba_pkg::FMT_W-1:0]         req_pixel_format,
   input  wire logic                               req_align_to_page,
   input  wire logic [vtba_pkg::ADDR_W-1:0]        req_free_address,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [vtba_pkg::ADDR_W-1:0]        rsp_result_address,
   output logic      [vtba_pkg::SIZE_W-1:0]        rsp_size_words,
   output logic                                    rsp_success,
   output logic      [vtba_pkg::ADDR_W-1:0]        rsp_free_words,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [vtba_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [vtba_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic      [vtba_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                    pready
);
   import vtba_pkg::*;

   // configuration
   logic [ADDR_W-1:0] limit_ff;
   logic              csr_write;

   // request register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [ACT_W-1:0]  s1_action_ff;
   logic [DIM_W-1:0]  s1_width_ff;
   logic [DIM_W-1:0]  s1_height_ff;
   logic [FMT_W-1:0]  s1_format_ff;
   logic              s1_align_ff;
   logic [ADDR_W-1:0] s1_free_address_ff;

   // size register
   logic              s2_valid_ff;
   logic              s2_valid_in;
   stage_item_type    s2_item_ff;
   stage_item_type    s2_item_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   logic              out_move;
   logic              s2_move;
   logic              s1_move;
   logic              req_take;
   logic [SIZE_W-1:0] calc_size;

   // each stage advances when the one after it has room
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign s2_move   = !s2_valid_ff || out_move;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;
   assign req_take  = req_valid && s1_move;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_LIMIT);
   assign prdata    = (paddr[2] == REG_LIMIT) ? CSR_DATA_W'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         limit_ff <= pwdata[ADDR_W-1:0];
      end
   end

   assign s1_valid_in  = s1_move ? req_valid : s1_valid_ff;
   assign s2_valid_in  = s2_move ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_move ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff       <= req_action;
         s1_width_ff        <= req_surface_width;
         s1_height_ff       <= req_surface_height;
         s1_format_ff       <= req_pixel_format;
         s1_align_ff        <= req_align_to_page;
         s1_free_address_ff <= req_free_address;
      end
   end

   vtba_size u_size (
      .surface_width  (s1_width_ff),
      .surface_height (s1_height_ff),
      .pixel_format   (s1_format_ff),
      .align_to_page  (s1_align_ff),
      .size_words     (calc_size)
   );

   // drop the size for frees and unknown formats
   always_comb begin
      s2_item_in.action       = s1_action_ff;
      s2_item_in.fmt_ok       = s1_format_ff <= FMT_LAST;
      s2_item_in.free_address = s1_free_address_ff;
      if (s1_action_ff == ACT_FREE || s1_format_ff > FMT_LAST) begin
         s2_item_in.size_words = '0;
      end else begin
         s2_item_in.size_words = calc_size;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move && s1_valid_ff) begin
         s2_item_ff <= s2_item_in;
      end
   end

   vtba_alloc u_alloc (
      .clock          (clock),
      .reset          (reset),
      .load           (s2_valid_ff && out_move),
      .item           (s2_item_ff),
      .vram_limit     (limit_ff),
      .result_address (rsp_result_address),
      .size_words     (rsp_size_words),
      .success        (rsp_success),
      .free_words     (rsp_free_words)
   );

   assign rsp_valid = rsp_valid_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_valid_ff))
      else $error("request stalled with room in the pipeline");

   a_size_block_multiple: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_item_ff.size_words[5:0] == 6'd0 ||
                       s2_item_ff.size_words == SIZE_SAT))
      else $error("surface size is not a whole number of blocks");

   a_free_within_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_free_words <= limit_ff))
      else $error("free word count exceeds the VRAM limit");

endmodule

`default_nettype wire

[tb/sv/tb_vram_texture_bump_allocator_core.sv]
// Self-checking testbench for the VRAM bump allocator core.
`timescale 1ns / 1ps

module tb_vram_texture_bump_allocator_core;
   import vtba_pkg::*;

   localparam logic [ACT_W-1:0]      ACT_RESERVED   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_REG_ADDR = 3'd0;
   localparam logic [ADDR_W-1:0]     LIMIT_DEFAULT  = 21'h10_0000;
   localparam logic [ADDR_W-1:0]     LIMIT_MAX      = 21'h1F_FFFF;
   localparam longint unsigned       SIZE_CEILING   = 64'h7F_FFFF;
   localparam int unsigned           BLOCK_WORDS    = 64;
   localparam int unsigned           PAGE_WORDS     = 2048;
   localparam int unsigned           PAGE_BLOCKS    = 32;
   localparam int                    DRAIN_CYCLES   = 8;
   localparam int                    RANDOM_PHASES  = 6;
   localparam int                    PHASE_ITEMS    = 200;

   typedef enum logic [FMT_W-1:0] {
      PSM_C32, PSM_C24, PSM_C16, PSM_C16S, PSM_C8, PSM_C4, PSM_C8H, PSM_C4HL,
      PSM_C4HH, PSM_Z32, PSM_Z24, PSM_Z16, PSM_Z16S, PSM_BAD13, PSM_BAD14, PSM_BAD15
   } pixel_fmt_type;

   // per-format block and page geometry in pixels
   localparam int unsigned BLK_W_PX [13] = '{8, 8, 16, 16, 16, 32, 8, 8, 8, 8, 8, 16, 16};
   localparam int unsigned BLK_H_PX [13] = '{8, 8, 8, 8, 16, 16, 8, 8, 8, 8, 8, 8, 8};
   localparam int unsigned PG_W_PX  [13] = '{64, 64, 64, 64, 128, 128, 64, 64, 64, 64, 64,
                                             64, 64};
   localparam int unsigned PG_H_PX  [13] = '{32, 32, 64, 64, 64, 128, 32, 32, 32, 32, 32,
                                             64, 64};
   // sections stacked vertically when set
   localparam bit          STACKED  [13] = '{0, 0, 1, 1, 0, 1, 0, 0, 0, 0, 0, 1, 1};
   localparam int unsigned OFS_SET  [13] = '{0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 0, 1, 3};
   localparam int unsigned SECT_MAJOR [8] = '{2, 2, 4, 4, 2, 2, 4, 4};
   localparam int unsigned SECT_MINOR [8] = '{2, 4, 2, 4, 6, 8, 6, 8};
   localparam int unsigned SECT_OFS [4][8] = '{
      '{0, 4, 8, 12, 16, 20, 24, 28},
      '{24, 28, 16, 20, 8, 12, 0, 4},
      '{0, 8, 16, 24, 4, 12, 4, 28},
      '{24, 16, 8, 0, 28, 20, 12, 4}};

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [FMT_W-1:0]  fmt;
      logic              page_align;
      logic [ADDR_W-1:0] free_address;
   } surface_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] size_words;
      logic              success;
      logic [ADDR_W-1:0] free_words;
   } alloc_result_type;

   logic                  clock;
   logic                  reset              = 1'b1;
   logic                  req_valid          = 1'b0;
   logic                  req_stall;
   logic [ACT_W-1:0]      req_action         = '0;
   logic [DIM_W-1:0]      req_surface_width  = '0;
   logic [DIM_W-1:0]      req_surface_height = '0;
   logic [FMT_W-1:0]      req_pixel_format   = '0;
   logic                  req_align_to_page  = 1'b0;
   logic [ADDR_W-1:0]     req_free_address   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall          = 1'b0;
   logic [ADDR_W-1:0]     rsp_result_address;
   logic [SIZE_W-1:0]     rsp_size_words;
   logic                  rsp_success;
   logic [ADDR_W-1:0]     rsp_free_words;
   logic                  psel               = 1'b0;
   logic                  penable            = 1'b0;
   logic                  pwrite             = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr              = '0;
   logic [CSR_DATA_W-1:0] pwdata             = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   alloc_result_type  expected_results[$];
   logic [ADDR_W-1:0] pointer_model = '0;
   logic [ADDR_W-1:0] limit_model   = LIMIT_DEFAULT;
   int unsigned       sender_idle_pct = 0;
   int unsigned       rsp_stall_pct   = 0;
   int unsigned       mismatch_count  = 0;

   vram_texture_bump_allocator_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_surface_width  (req_surface_width),
      .req_surface_height (req_surface_height),
      .req_pixel_format   (req_pixel_format),
      .req_align_to_page  (req_align_to_page),
      .req_free_address   (req_free_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_address (rsp_result_address),
      .rsp_size_words     (rsp_size_words),
      .rsp_success        (rsp_success),
      .rsp_free_words     (rsp_free_words),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      mismatch_count++;
      $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   // pages along one axis; tail is the pixel count in the last page
   function automatic int unsigned page_span(input int unsigned len, input int unsigned page,
                                             output int unsigned tail);
      int unsigned n;
      n = len / page;
      tail = len - page * n;
      if (tail == 0) tail = page;
      else n++;
      return n;
   endfunction

   function automatic longint unsigned texture_words(input int unsigned w, input int unsigned h,
                                                     input int unsigned f, input bit page_align);
      int unsigned tw, th, major, minor, sect, quad;
      longint unsigned pages, blocks, words, al;
      bit found;
      if (w == 0 || h == 0) return 0;
      pages = longint'(page_span(w, PG_W_PX[f], tw));
      pages = pages * page_span(h, PG_H_PX[f], th);
      blocks = (pages - 1) * PAGE_BLOCKS;
      if (STACKED[f]) begin
         major = tw / BLK_W_PX[f];
         minor = th / BLK_H_PX[f];
      end else begin
         major = th / BLK_H_PX[f];
         minor = tw / BLK_W_PX[f];
      end
      sect = 0;
      found = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!found && major <= SECT_MAJOR[i] && minor <= SECT_MINOR[i]) begin
            sect = SECT_OFS[OFS_SET[f]][i];
            found = 1'b1;
         end
      end
      if (major == 0) major = 1;
      if (minor == 0) minor = 1;
      quad = ((((major & 1) << 1) | (minor & 1)) ^ 3) + 1;
      words = (blocks + sect + quad) * BLOCK_WORDS;
      al = page_align ? PAGE_WORDS : BLOCK_WORDS;
      return (words + al - 1) & ~(al - 1);
   endfunction

   // advance the pointer model and queue the result this request must produce
   task automatic predict_allocation(input surface_req_type rq);
      alloc_result_type r;
      longint unsigned sz, nxt;
      r = '0;
      if (rq.action == ACT_FREE) begin
         pointer_model = rq.free_address;
         r.success = 1'b1;
      end else if (rq.fmt <= PSM_Z16S) begin
         sz = texture_words(rq.width, rq.height, rq.fmt, rq.page_align);
         if (sz > SIZE_CEILING) sz = SIZE_CEILING;
         r.size_words = sz[SIZE_W-1:0];
         if (rq.action == ACT_QUERY) begin
            r.success = 1'b1;
         end else if (rq.action == ACT_ALLOC) begin
            nxt = pointer_model + sz;
            if (nxt <= limit_model) begin
               r.address = pointer_model;
               pointer_model = nxt[ADDR_W-1:0];
               r.success = 1'b1;
            end
         end
      end
      r.free_words = (limit_model > pointer_model) ? limit_model - pointer_model : '0;
      expected_results.push_back(r);
   endtask

   always @(posedge clock) begin : check_results
      alloc_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_size_words, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_result_address !== want.address)
               report_mismatch("result_address", rsp_result_address, want.address);
            if (rsp_size_words !== want.size_words)
               report_mismatch("size_words", rsp_size_words, want.size_words);
            if (rsp_success !== want.success)
               report_mismatch("success", rsp_success, want.success);
            if (rsp_free_words !== want.free_words)
               report_mismatch("free_words", rsp_free_words, want.free_words);
         end
      end
   end

   // leave valid high after the transfer so back-to-back requests need no bubble
   task automatic send_request(input surface_req_type rq);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_valid          <= 1'b1;
      req_action         <= rq.action;
      req_surface_width  <= rq.width;
      req_surface_height <= rq.height;
      req_pixel_format   <= rq.fmt;
      req_align_to_page  <= rq.page_align;
      req_free_address   <= rq.free_address;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_allocation(rq);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the limit, then read it back in a back-to-back access
   task automatic write_vram_limit(input logic [ADDR_W-1:0] value);
      wait_for_results();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_REG_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      limit_model = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(value)) report_mismatch("limit readback", prdata, value);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic surface_req_type make_req(input logic [ACT_W-1:0] action,
                                                input int unsigned w, input int unsigned h,
                                                input logic [FMT_W-1:0] fmt,
                                                input bit page_align,
                                                input logic [ADDR_W-1:0] faddr);
      surface_req_type rq;
      rq.action       = action;
      rq.width        = w[DIM_W-1:0];
      rq.height       = h[DIM_W-1:0];
      rq.fmt          = fmt;
      rq.page_align   = page_align;
      rq.free_address = faddr;
      return rq;
   endfunction

   function automatic int unsigned random_dim();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)  return 0;
      if (pick < 70) return $urandom_range(1, 256);
      if (pick < 92) return $urandom_range(1, 2048);
      return $urandom_range(0, 4095);
   endfunction

   function automatic surface_req_type random_request();
      surface_req_type rq;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      rq.action = ACT_QUERY;
      else if (pick < 75) rq.action = ACT_ALLOC;
      else if (pick < 94) rq.action = ACT_FREE;
      else                rq.action = ACT_RESERVED;
      rq.width      = DIM_W'(random_dim());
      rq.height     = DIM_W'(random_dim());
      rq.fmt        = FMT_W'(($urandom_range(0, 99) < 94) ? $urandom_range(0, 12)
                                                          : $urandom_range(13, 15));
      rq.page_align = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 50)      rq.free_address = ADDR_W'($urandom_range(0, 4095) * BLOCK_WORDS);
      else if (pick < 80) rq.free_address = ADDR_W'($urandom_range(0, LIMIT_DEFAULT));
      else                rq.free_address = ADDR_W'($urandom);
      return rq;
   endfunction

   // zero dimensions, a selection of formats, page and block alignment, saturation, bad codes
   task automatic test_size_rule();
      send_request(make_req(ACT_QUERY, 0, 7, PSM_C32, 0, '0));
      send_request(make_req(ACT_QUERY, 9, 0, PSM_C8, 1, '0));
      send_request(make_req(ACT_QUERY, 1, 1, PSM_C32, 0, '0));
      send_request(make_req(ACT_QUERY, 1, 1, PSM_C32, 1, '0));
      send_request(make_req(ACT_QUERY, 2048, 2048, PSM_C4, 1, '0));
      send_request(make_req(ACT_QUERY, 4095, 4095, PSM_C32, 0, '0));
      send_request(make_req(ACT_QUERY, 100, 40, PSM_C16S, 0, '0));
      send_request(make_req(ACT_QUERY, 30, 20, PSM_Z16S, 0, '0));
      send_request(make_req(ACT_QUERY, 33, 17, PSM_Z16, 0, '0));
      send_request(make_req(ACT_QUERY, 65, 33, PSM_C4HH, 0, '0));
      send_request(make_req(ACT_QUERY, 64, 64, PSM_BAD13, 0, '0));
      send_request(make_req(ACT_QUERY, 64, 64, PSM_BAD15, 1, '0));
      send_request(make_req(ACT_RESERVED, 48, 24, PSM_C16, 0, LIMIT_MAX));
   endtask

   task automatic test_alloc_free();
      send_request(make_req(ACT_ALLOC, 64, 32, PSM_C32, 1, '0));
      send_request(make_req(ACT_ALLOC, 4095, 4095, PSM_C32, 1, '0));
      send_request(make_req(ACT_ALLOC, 16, 16, PSM_BAD14, 0, '0));
      // free past the limit: free_words reads zero and the next allocate fails
      send_request(make_req(ACT_FREE, 0, 0, PSM_C32, 0, LIMIT_MAX));
      send_request(make_req(ACT_ALLOC, 1, 1, PSM_Z24, 0, '0));
      send_request(make_req(ACT_FREE, 4095, 4095, PSM_BAD15, 1, '0));
      send_request(make_req(ACT_ALLOC, 1, 1, PSM_Z32, 0, '0));
   endtask

   task automatic test_limit_extremes();
      write_vram_limit('0);
      send_request(make_req(ACT_FREE, 0, 0, PSM_C32, 0, '0));
      send_request(make_req(ACT_ALLOC, 0, 5, PSM_C32, 0, '0));
      send_request(make_req(ACT_ALLOC, 1, 1, PSM_C32, 0, '0));
      write_vram_limit(LIMIT_MAX);
      send_request(make_req(ACT_FREE, 0, 0, PSM_C32, 0, 21'h1F_FF80));
      send_request(make_req(ACT_ALLOC, 1, 1, PSM_C24, 0, '0));
      send_request(make_req(ACT_ALLOC, 1, 1, PSM_C24, 0, '0));
      write_vram_limit(LIMIT_DEFAULT);
   endtask

   task automatic test_random_traffic();
      logic [ADDR_W-1:0] limits [RANDOM_PHASES];
      int unsigned idle_modes [4][2];
      idle_modes = '{'{0, 0}, '{60, 0}, '{0, 60}, '{23, 23}};
      limits = '{LIMIT_DEFAULT, LIMIT_MAX, '0, ADDR_W'($urandom_range(4096, 200000)),
                 ADDR_W'($urandom_range(0, LIMIT_MAX)), LIMIT_DEFAULT};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_vram_limit(limits[p]);
         sender_idle_pct = idle_modes[p % 4][0];
         rsp_stall_pct   = idle_modes[p % 4][1];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_request(random_request());
            // hold off once mid-phase until the pipeline is empty
            if (n == PHASE_ITEMS / 2) wait_for_results();
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_size_rule();
      test_alloc_free();
      test_limit_extremes();
      test_random_traffic();
      wait_for_results();
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[vram_texture_bump_allocator_core.f]
src/vtba_pkg.sv
src/vtba_size.sv
src/vtba_alloc.sv
src/vram_texture_bump_allocator_core.sv
tb/sv/tb_vram_texture_bump_allocator_core.sv
